### hw/rtl/dga_pkg.sv
`timescale 1ns / 1ps

package dga_pkg;

  localparam int FrontStages = 3;
  localparam int SqrtSteps   = 32;
  localparam int BackStages  = 3;
  localparam int Latency     = FrontStages + SqrtSteps + BackStages;

  localparam logic signed [31:0] GravityReset = -32'sd2108555;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic [31:0]        k;
    logic               sat;
  } rel_t;

  // Returns {clamped flag, value} for a 33-bit signed difference.
  function automatic logic [32:0] clamp33(input logic signed [32:0] v);
    logic [32:0] res;
    if (v > 33'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -33'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // Returns {clamped flag, value} for a 50-bit signed sum.
  function automatic logic [32:0] clamp50(input logic signed [49:0] v);
    logic [32:0] res;
    if (v > 50'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -50'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### hw/rtl/drag_gravity_acceleration.sv
`timescale 1ns / 1ps

// Quadratic drag plus gravity in Q16.16. A beat is taken on every cycle that
// start is high (busy stays low), and its result appears with done high once
// the front stages have formed the relative velocity and squared speed, the
// square root stages have run one result bit per stage, and the back stages
// have done the drag multiplies and clamping. One beat per cycle is sustained. The receiver
// cannot stall, so each done pulse must be captured when it appears. Write
// gravity only while no beat is in flight.
module drag_gravity_acceleration (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] velocity_x_i,
  input  logic signed [31:0] velocity_y_i,
  input  logic signed [31:0] velocity_z_i,
  input  logic signed [31:0] wind_x_i,
  input  logic signed [31:0] wind_y_i,
  input  logic signed [31:0] wind_z_i,
  input  logic [31:0]        drag_coeff_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  output logic               saturated_o
);

  logic signed [31:0] gravity_q;
  logic               f_vld, s_vld;
  logic [63:0]        f_sum;
  dga_pkg::rel_t      f_rel, s_rel;
  logic [31:0]        s_root;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= dga_pkg::GravityReset;
    end else if (cfg_we_i) begin
      gravity_q <= cfg_wdata_i;
    end
  end

  dga_front u_front (
    .clk_i, .rst_ni,
    .vld_i(start & ~busy),
    .velocity_x_i, .velocity_y_i, .velocity_z_i,
    .wind_x_i, .wind_y_i, .wind_z_i, .drag_coeff_i,
    .vld_o(f_vld), .sum_o(f_sum), .rel_o(f_rel)
  );

  dga_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .vld_i(f_vld), .sum_i(f_sum), .rel_i(f_rel),
    .vld_o(s_vld), .root_o(s_root), .rel_o(s_rel)
  );

  dga_back u_back (
    .clk_i, .rst_ni,
    .vld_i(s_vld), .root_i(s_root), .rel_i(s_rel), .gravity_i(gravity_q),
    .vld_o(done_o), .accel_x_o, .accel_y_o, .accel_z_o, .saturated_o
  );

endmodule

### hw/rtl/dga_front.sv
`timescale 1ns / 1ps

module dga_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic signed [31:0] velocity_x_i,
  input  logic signed [31:0] velocity_y_i,
  input  logic signed [31:0] velocity_z_i,
  input  logic signed [31:0] wind_x_i,
  input  logic signed [31:0] wind_y_i,
  input  logic signed [31:0] wind_z_i,
  input  logic [31:0]        drag_coeff_i,
  output logic               vld_o,
  output logic [63:0]        sum_o,
  output dga_pkg::rel_t      rel_o
);

  logic          vld1_q, vld2_q, vld3_q;
  dga_pkg::rel_t rel1_d, rel1_q, rel2_q, rel3_q;
  logic [32:0]   cx, cy, cz;
  logic [63:0]   sqx_q, sqy_q, sqz_q, sum_q;

  always_comb begin
    cx = dga_pkg::clamp33(33'(velocity_x_i) - 33'(wind_x_i));
    cy = dga_pkg::clamp33(33'(velocity_y_i) - 33'(wind_y_i));
    cz = dga_pkg::clamp33(33'(velocity_z_i) - 33'(wind_z_i));
    rel1_d.rx  = cx[31:0];
    rel1_d.ry  = cy[31:0];
    rel1_d.rz  = cz[31:0];
    rel1_d.k   = drag_coeff_i;
    rel1_d.sat = cx[32] | cy[32] | cz[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rel1_q <= rel1_d;
    sqx_q  <= 64'(dga_pkg::mag32(rel1_q.rx)) * 64'(dga_pkg::mag32(rel1_q.rx));
    sqy_q  <= 64'(dga_pkg::mag32(rel1_q.ry)) * 64'(dga_pkg::mag32(rel1_q.ry));
    sqz_q  <= 64'(dga_pkg::mag32(rel1_q.rz)) * 64'(dga_pkg::mag32(rel1_q.rz));
    rel2_q <= rel1_q;
    sum_q  <= sqx_q + sqy_q + sqz_q;
    rel3_q <= rel2_q;
  end

  assign vld_o = vld3_q;
  assign sum_o = sum_q;
  assign rel_o = rel3_q;

endmodule

### hw/rtl/dga_sqrt.sv
`timescale 1ns / 1ps

module dga_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [63:0]   sum_i,
  input  dga_pkg::rel_t rel_i,
  output logic          vld_o,
  output logic [31:0]   root_o,
  output dga_pkg::rel_t rel_o
);

  // One result bit per stage, restoring digit recurrence.
  logic          vld_q  [dga_pkg::SqrtSteps];
  logic [33:0]   rem_q  [dga_pkg::SqrtSteps];
  logic [31:0]   root_q [dga_pkg::SqrtSteps];
  logic [63:0]   num_q  [dga_pkg::SqrtSteps];
  dga_pkg::rel_t rel_q  [dga_pkg::SqrtSteps];

  for (genvar j = 0; j < dga_pkg::SqrtSteps; j++) begin : g_step
    logic          src_vld;
    logic [33:0]   src_rem;
    logic [31:0]   src_root;
    logic [63:0]   src_num;
    dga_pkg::rel_t src_rel;
    logic [33:0]   rem_sh, trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign src_vld  = vld_i;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_num  = sum_i;
      assign src_rel  = rel_i;
    end else begin : g_next
      assign src_vld  = vld_q[j-1];
      assign src_rem  = rem_q[j-1];
      assign src_root = root_q[j-1];
      assign src_num  = num_q[j-1];
      assign src_rel  = rel_q[j-1];
    end

    always_comb begin
      rem_sh = {src_rem[31:0], src_num[63:62]};
      trial  = {src_root, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? rem_sh - trial : rem_sh;
      root_q[j] <= {src_root[30:0], ge};
      num_q[j]  <= {src_num[61:0], 2'b00};
      rel_q[j]  <= src_rel;
    end
  end

  assign vld_o  = vld_q[dga_pkg::SqrtSteps-1];
  assign root_o = root_q[dga_pkg::SqrtSteps-1];
  assign rel_o  = rel_q[dga_pkg::SqrtSteps-1];

endmodule

### hw/rtl/dga_back.sv
`timescale 1ns / 1ps

module dga_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [31:0]        root_i,
  input  dga_pkg::rel_t      rel_i,
  input  logic signed [31:0] gravity_i,
  output logic               vld_o,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  output logic               saturated_o
);

  logic          vld1_q, vld2_q, vld3_q;
  logic [63:0]   prod;
  logic [31:0]   d_q;
  dga_pkg::rel_t rel1_q;
  logic [47:0]   mx_q, my_q, mz_q;
  logic          nx_q, ny_q, nz_q, sat2_q;
  logic signed [49:0] ax, ay, az;
  logic [32:0]   cx, cy, cz;
  logic signed [31:0] accx_q, accy_q, accz_q;
  logic          sat3_q;

  assign prod = 64'(rel_i.k) * 64'(root_i);

  always_comb begin
    ax = nx_q ? $signed({2'b00, mx_q}) : -$signed({2'b00, mx_q});
    ay = ny_q ? $signed({2'b00, my_q}) : -$signed({2'b00, my_q});
    az = nz_q ? $signed({2'b00, mz_q}) : -$signed({2'b00, mz_q});
    ay = ay + 50'(gravity_i);
    cx = dga_pkg::clamp50(ax);
    cy = dga_pkg::clamp50(ay);
    cz = dga_pkg::clamp50(az);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= prod[63:32];
    rel1_q <= rel_i;
    mx_q   <= 48'((64'(dga_pkg::mag32(rel1_q.rx)) * 64'(d_q)) >> 16);
    my_q   <= 48'((64'(dga_pkg::mag32(rel1_q.ry)) * 64'(d_q)) >> 16);
    mz_q   <= 48'((64'(dga_pkg::mag32(rel1_q.rz)) * 64'(d_q)) >> 16);
    nx_q   <= rel1_q.rx[31];
    ny_q   <= rel1_q.ry[31];
    nz_q   <= rel1_q.rz[31];
    sat2_q <= rel1_q.sat;
    accx_q <= cx[31:0];
    accy_q <= cy[31:0];
    accz_q <= cz[31:0];
    sat3_q <= sat2_q | cx[32] | cy[32] | cz[32];
  end

  assign vld_o       = vld3_q;
  assign accel_x_o   = accx_q;
  assign accel_y_o   = accy_q;
  assign accel_z_o   = accz_q;
  assign saturated_o = sat3_q;

endmodule

### hw/rtl/dga_checker.sv
`timescale 1ns / 1ps

module dga_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] velocity_x_i,
  input logic signed [31:0] wind_x_i,
  input logic               done_o,
  input logic signed [31:0] accel_x_o
);

  // Every accepted beat produces a result after the fixed latency.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(dga_pkg::Latency) done_o)
    else $error("accepted beat produced no result");

  // No result without a beat accepted the fixed latency before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, dga_pkg::Latency))
    else $error("result without matching beat");

  // Zero relative x velocity yields zero x acceleration.
  a_zero_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && velocity_x_i == wind_x_i |-> ##(dga_pkg::Latency) accel_x_o == 0)
    else $error("nonzero x drag at zero relative x velocity");

endmodule

bind drag_gravity_acceleration dga_checker u_dga_checker (
  .clk_i, .rst_ni, .start, .busy, .velocity_x_i, .wind_x_i, .done_o, .accel_x_o
);
